// ----- rtl/mips_pkg.sv -----
package mips_pkg;

	localparam logic [1:0] ACT_MEM_WRITE = 2'd0;
	localparam logic [1:0] ACT_EXECUTE   = 2'd1;
	localparam logic [1:0] ACT_MEM_READ  = 2'd2;
	localparam logic [1:0] ACT_REG_READ  = 2'd3;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2B;

	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;

	localparam logic [5:0] SEL_PC = 6'd32;
	localparam logic [5:0] SEL_HI = 6'd33;
	localparam logic [5:0] SEL_LO = 6'd34;

	localparam logic [31:0] SYS_PRINT_INT = 32'd1;
	localparam logic [31:0] SYS_EXIT      = 32'd10;

	// controller to datapath
	typedef struct packed {
		logic load_in;     // capture input word
		logic mem_req;     // drive memory port from input word
		logic fetch;       // read instruction at pc
		logic decode;      // latch instruction, read rs/rt
		logic execute;     // compute, start mem access
		logic div_start;
		logic div_step;
		logic retire;      // commit results
		logic reg_read;    // form register readback
		logic mem_read;    // take memory readback
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_div;
		logic div_done;
		logic halted;
	} sts_t;

endpackage

// ----- rtl/mips_ram.sv -----
module mips_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- rtl/mips_ctrl.sv -----
module mips_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      in_action,
	output logic            out_valid,
	input  logic            out_ready,
	input  mips_pkg::sts_t  sts,
	output mips_pkg::ctl_t  ctl
);
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MEMOP  = 4'd1;
	localparam logic [3:0] ST_MEMRD  = 4'd2;
	localparam logic [3:0] ST_FETCH  = 4'd3;
	localparam logic [3:0] ST_DECODE = 4'd4;
	localparam logic [3:0] ST_EXEC   = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_WB     = 4'd7;
	localparam logic [3:0] ST_REGRD  = 4'd8;
	localparam logic [3:0] ST_OUT    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_valid_d;
	logic       take;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	// result word must leave before the next word is taken
	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		ctl         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					ctl.load_in = 1'b1;
					unique case (in_action)
						mips_pkg::ACT_MEM_WRITE: state_d = ST_MEMOP;
						mips_pkg::ACT_MEM_READ:  state_d = ST_MEMOP;
						mips_pkg::ACT_EXECUTE:   state_d = ST_FETCH;
						default:                 state_d = ST_REGRD;
					endcase
				end
			end
			ST_MEMOP: begin
				ctl.mem_req = 1'b1;
				state_d     = ST_MEMRD;
			end
			ST_MEMRD: begin
				ctl.mem_read = 1'b1;
				state_d      = ST_OUT;
			end
			ST_FETCH: begin
				if (sts.halted) begin
					state_d = ST_OUT;
				end else begin
					ctl.fetch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				ctl.decode = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				ctl.execute = 1'b1;
				if (sts.is_div) begin
					ctl.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_WB;
				end
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				ctl.retire = 1'b1;
				state_d    = ST_OUT;
			end
			ST_REGRD: begin
				ctl.reg_read = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end
endmodule

// ----- rtl/mips_dpath.sv -----
module mips_dpath #(
	parameter int MEM_WORDS = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mips_pkg::ctl_t  ctl,
	output mips_pkg::sts_t  sts,
	input  logic [1:0]      in_action,
	input  logic [13:0]     in_address,
	input  logic [31:0]     in_write_data,
	input  logic [5:0]      in_reg_select,
	output logic [31:0]     read_data,
	output logic [31:0]     pc_value,
	output logic            halted,
	output logic            print_valid,
	output logic [31:0]     print_value
);
	localparam int AW = $clog2(MEM_WORDS);

	logic [31:0] regs_q [32];
	logic [31:0] pc_q, hi_q, lo_q;
	logic        halt_q;
	logic [1:0]  act_q;
	logic [13:0] addr_q;
	logic [31:0] wd_q;
	logic [5:0]  sel_q;
	logic [31:0] ins_q, a_q, b_q;
	logic [31:0] res_q, next_q, ea_q;
	logic        wr_q, prt_q;
	logic [4:0]  dst_q;
	logic [5:0]  opx_q;
	logic [63:0] prod_q;
	logic        mult_q;
	logic [31:0] out_rd_q, out_pr_q;
	logic        out_pv_q;

	// memory port
	logic           mem_we;
	logic [AW-1:0]  mem_addr;
	logic [31:0]    mem_wdata, mem_rdata;
	logic [31:0]    addr_ext;

	// decode fields
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [15:0] imm;
	logic [31:0] simm, zimm, nxt, btgt, jtgt, ea;
	logic [4:0]  bsh;
	logic        hsel;

	assign op   = ins_q[31:26];
	assign rs   = ins_q[25:21];
	assign rt   = ins_q[20:16];
	assign rd   = ins_q[15:11];
	assign sh   = ins_q[10:6];
	assign fn   = ins_q[5:0];
	assign imm  = ins_q[15:0];
	assign simm = {{16{imm[15]}}, imm};
	assign zimm = {16'd0, imm};
	assign nxt  = pc_q + 32'd4;
	assign btgt = nxt + {simm[29:0], 2'b00};
	assign jtgt = {nxt[31:28], ins_q[25:0], 2'b00};
	assign ea   = a_q + simm;

	assign addr_ext = {18'd0, addr_q};

	// divider: restoring, one quotient bit per cycle
	logic [31:0] dv_rem_q, dv_quo_q, dv_den_q;
	logic [5:0]  dv_cnt_q;
	logic        dv_na_q, dv_nb_q, dv_zero_q;
	logic [32:0] dv_trial;
	logic [31:0] ua, ub;

	assign ua       = a_q[31] ? (32'd0 - a_q) : a_q;
	assign ub       = b_q[31] ? (32'd0 - b_q) : b_q;
	assign dv_trial = {dv_rem_q, dv_quo_q[31]} - {1'b0, dv_den_q};

	assign sts.is_div   = (op == mips_pkg::OP_SPECIAL) && (fn == mips_pkg::FN_DIV);
	assign sts.div_done = (dv_cnt_q == 6'd0);
	assign sts.halted   = halt_q;

	// memory address and write data
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = pc_q[AW+1:2];
		mem_wdata = in_write_data;
		if (ctl.mem_req) begin
			mem_addr  = addr_ext[AW+1:2];
			mem_we    = (act_q == mips_pkg::ACT_MEM_WRITE);
			mem_wdata = wd_q;
		end else if (ctl.execute) begin
			mem_addr = ea[AW+1:2];
		end else if (ctl.retire) begin
			mem_addr  = ea_q[AW+1:2];
			mem_wdata = mem_rdata;
			unique case (opx_q)
				mips_pkg::OP_SW: begin
					mem_we    = 1'b1;
					mem_wdata = b_q;
				end
				mips_pkg::OP_SH: begin
					mem_we = 1'b1;
					if (ea_q[1]) mem_wdata[31:16] = b_q[15:0];
					else mem_wdata[15:0] = b_q[15:0];
				end
				mips_pkg::OP_SB: begin
					mem_we = 1'b1;
					case (ea_q[1:0])
						2'd0: mem_wdata[7:0]   = b_q[7:0];
						2'd1: mem_wdata[15:8]  = b_q[7:0];
						2'd2: mem_wdata[23:16] = b_q[7:0];
						default: mem_wdata[31:24] = b_q[7:0];
					endcase
				end
				default: mem_we = 1'b0;
			endcase
		end
	end

	mips_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// load data alignment
	logic [7:0]  lbyte;
	logic [15:0] lhalf;
	assign bsh   = {ea_q[1:0], 3'b000};
	assign hsel  = ea_q[1];
	assign lbyte = 8'(mem_rdata >> bsh);
	assign lhalf = hsel ? mem_rdata[31:16] : mem_rdata[15:0];

	// execute
	logic [31:0] ex_res, ex_next;
	logic        ex_wr, ex_prt, ex_halt, ex_mult;
	logic [4:0]  ex_dst;

	always_comb begin
		ex_res  = '0;
		ex_next = nxt;
		ex_wr   = 1'b0;
		ex_dst  = rt;
		ex_prt  = 1'b0;
		ex_halt = 1'b0;
		ex_mult = 1'b0;
		unique case (op)
			mips_pkg::OP_SPECIAL: begin
				ex_dst = rd;
				unique case (fn)
					mips_pkg::FN_SLL: begin ex_wr = 1'b1; ex_res = b_q << sh; end
					mips_pkg::FN_SRL: begin ex_wr = 1'b1; ex_res = b_q >> sh; end
					mips_pkg::FN_SRA: begin
						ex_wr  = 1'b1;
						ex_res = 32'($signed(b_q) >>> sh);
					end
					mips_pkg::FN_JR: ex_next = a_q;
					mips_pkg::FN_SYSCALL: begin
						ex_prt  = (regs_q[2] == mips_pkg::SYS_PRINT_INT);
						ex_halt = (regs_q[2] == mips_pkg::SYS_EXIT);
					end
					mips_pkg::FN_MFHI: begin ex_wr = 1'b1; ex_res = hi_q; end
					mips_pkg::FN_MFLO: begin ex_wr = 1'b1; ex_res = lo_q; end
					mips_pkg::FN_MULT: ex_mult = 1'b1;
					mips_pkg::FN_ADD: begin ex_wr = 1'b1; ex_res = a_q + b_q; end
					mips_pkg::FN_SUB: begin ex_wr = 1'b1; ex_res = a_q - b_q; end
					mips_pkg::FN_AND: begin ex_wr = 1'b1; ex_res = a_q & b_q; end
					mips_pkg::FN_OR:  begin ex_wr = 1'b1; ex_res = a_q | b_q; end
					mips_pkg::FN_XOR: begin ex_wr = 1'b1; ex_res = a_q ^ b_q; end
					mips_pkg::FN_NOR: begin ex_wr = 1'b1; ex_res = ~(a_q | b_q); end
					mips_pkg::FN_SLT: begin
						ex_wr  = 1'b1;
						ex_res = {31'd0, $signed(a_q) < $signed(b_q)};
					end
					default: ex_wr = 1'b0;
				endcase
			end
			mips_pkg::OP_J: ex_next = jtgt;
			mips_pkg::OP_JAL: begin
				ex_next = jtgt;
				ex_wr   = 1'b1;
				ex_dst  = 5'd31;
				ex_res  = nxt;
			end
			mips_pkg::OP_BEQ: if (a_q == b_q) ex_next = btgt;
			mips_pkg::OP_BNE: if (a_q != b_q) ex_next = btgt;
			mips_pkg::OP_BLEZ: if (a_q == 32'd0 || a_q[31]) ex_next = btgt;
			mips_pkg::OP_BGTZ: if (a_q != 32'd0 && !a_q[31]) ex_next = btgt;
			mips_pkg::OP_ADDI, mips_pkg::OP_ADDIU: begin
				ex_wr  = 1'b1;
				ex_res = a_q + simm;
			end
			mips_pkg::OP_SLTI: begin
				ex_wr  = 1'b1;
				ex_res = {31'd0, $signed(a_q) < $signed(simm)};
			end
			mips_pkg::OP_SLTIU: begin
				ex_wr  = 1'b1;
				ex_res = {31'd0, a_q < simm};
			end
			mips_pkg::OP_ANDI: begin ex_wr = 1'b1; ex_res = a_q & zimm; end
			mips_pkg::OP_ORI:  begin ex_wr = 1'b1; ex_res = a_q | zimm; end
			mips_pkg::OP_XORI: begin ex_wr = 1'b1; ex_res = a_q ^ zimm; end
			mips_pkg::OP_LB, mips_pkg::OP_LH, mips_pkg::OP_LW,
			mips_pkg::OP_LBU, mips_pkg::OP_LHU: ex_wr = 1'b1;
			default: ex_wr = 1'b0;
		endcase
	end

	// retire value
	logic [31:0] wb_val;
	always_comb begin
		case (opx_q)
			mips_pkg::OP_LB:  wb_val = {{24{lbyte[7]}}, lbyte};
			mips_pkg::OP_LBU: wb_val = {24'd0, lbyte};
			mips_pkg::OP_LH:  wb_val = {{16{lhalf[15]}}, lhalf};
			mips_pkg::OP_LHU: wb_val = {16'd0, lhalf};
			mips_pkg::OP_LW:  wb_val = mem_rdata;
			default:          wb_val = res_q;
		endcase
	end

	// register readback
	logic [31:0] rr_val;
	always_comb begin
		if (sel_q < 6'd32) begin
			rr_val = regs_q[sel_q[4:0]];
		end else begin
			unique case (sel_q)
				mips_pkg::SEL_PC: rr_val = pc_q;
				mips_pkg::SEL_HI: rr_val = hi_q;
				mips_pkg::SEL_LO: rr_val = lo_q;
				default:          rr_val = 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			act_q  <= in_action;
			addr_q <= in_address;
			wd_q   <= in_write_data;
			sel_q  <= in_reg_select;
			out_rd_q <= 32'd0;
			out_pv_q <= 1'b0;
			out_pr_q <= 32'd0;
		end
		if (ctl.decode) begin
			ins_q <= mem_rdata;
			a_q   <= regs_q[mem_rdata[25:21]];
			b_q   <= regs_q[mem_rdata[20:16]];
		end
		if (ctl.execute) begin
			res_q  <= ex_res;
			next_q <= ex_next;
			wr_q   <= ex_wr;
			dst_q  <= ex_dst;
			prt_q  <= ex_prt;
			ea_q   <= ea;
			opx_q  <= op;
			mult_q <= ex_mult;
			prod_q <= 64'($signed(a_q) * $signed(b_q));
		end
		if (ctl.div_start) begin
			dv_rem_q  <= 32'd0;
			dv_quo_q  <= ua;
			dv_den_q  <= ub;
			dv_cnt_q  <= 6'd32;
			dv_na_q   <= a_q[31];
			dv_nb_q   <= b_q[31];
			dv_zero_q <= (ub == 32'd0);
		end else if (ctl.div_step && dv_cnt_q != 6'd0) begin
			if (!dv_trial[32]) begin
				dv_rem_q <= dv_trial[31:0];
				dv_quo_q <= {dv_quo_q[30:0], 1'b1};
			end else begin
				dv_rem_q <= {dv_rem_q[30:0], dv_quo_q[31]};
				dv_quo_q <= {dv_quo_q[30:0], 1'b0};
			end
			dv_cnt_q <= dv_cnt_q - 6'd1;
		end
		if (ctl.mem_read && act_q == mips_pkg::ACT_MEM_READ) begin
			out_rd_q <= mem_rdata;
		end
		if (ctl.reg_read) begin
			out_rd_q <= rr_val;
		end
		if (ctl.retire) begin
			out_pv_q <= prt_q;
			out_pr_q <= prt_q ? regs_q[4] : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) regs_q[i] <= 32'd0;
			pc_q   <= 32'd0;
			hi_q   <= 32'd0;
			lo_q   <= 32'd0;
			halt_q <= 1'b0;
		end else begin
			if (ctl.execute && ex_halt) begin
				halt_q <= 1'b1;
			end
			if (ctl.retire) begin
				pc_q <= next_q;
				if (wr_q && dst_q != 5'd0) begin
					regs_q[dst_q] <= wb_val;
				end
				if (mult_q) begin
					hi_q <= prod_q[63:32];
					lo_q <= prod_q[31:0];
				end
				if (sts.is_div && !dv_zero_q) begin
					lo_q <= (dv_na_q != dv_nb_q) ? (32'd0 - dv_quo_q) : dv_quo_q;
					hi_q <= dv_na_q ? (32'd0 - dv_rem_q) : dv_rem_q;
				end
			end
		end
	end

	assign read_data   = out_rd_q;
	assign pc_value    = pc_q;
	assign halted      = halt_q;
	assign print_valid = out_pv_q;
	assign print_value = out_pr_q;
endmodule

// ----- rtl/mips_integer_subset_core.sv -----
// Multicycle 32-bit MIPS integer subset core with an internal word memory.
// Each input word is one action: write or read a memory word, read a register
// (0-31 gprs, 32 pc, 33 hi, 34 lo), or execute the instruction at pc. One
// result word comes back per input word. A register read goes via the
// register-read and output states, a memory read or write via memory request,
// memory read and output, and an instruction via fetch, decode, execute,
// write back and output over the single-port memory; div adds a divide state
// for the one-bit-per-cycle divider. The next input word is accepted only
// once the previous result word has been taken. Branches have no delay slot,
// nothing traps, and after an exit syscall execute words change nothing.
module mips_integer_subset_core #(
	parameter int MEM_WORDS = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// action[1:0], address[15:2], write_data[47:16], reg_select[53:48]
	input  logic [55:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// read_data[31:0], pc_value[63:32], halted[64], print_valid[65],
	// print_value[97:66]
	output logic [103:0] m_tdata
);
	mips_pkg::ctl_t ctl;
	mips_pkg::sts_t sts;
	logic [31:0] read_data, pc_value, print_value;
	logic        halted, print_valid;

	mips_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tdata[1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.ctl       (ctl)
	);

	mips_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.in_action     (s_tdata[1:0]),
		.in_address    (s_tdata[15:2]),
		.in_write_data (s_tdata[47:16]),
		.in_reg_select (s_tdata[53:48]),
		.read_data     (read_data),
		.pc_value      (pc_value),
		.halted        (halted),
		.print_valid   (print_valid),
		.print_value   (print_value)
	);

	assign m_tdata = {6'd0, print_value, print_valid, halted, pc_value, read_data};
endmodule
